// File: hw/rtl/epoch_seconds_to_utc_calendar_assert.svh
// assertion macros for the epoch seconds to utc calendar block
// expects clk_i, rst_ni and out_valid_o in the including module
`ifndef EPOCH_SECONDS_TO_UTC_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_CALENDAR_ASSERT_SVH

// clocked property, switched off while reset is held
`define E2UTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must hold whenever a result request is offered
`define E2UTC_ASSERT_VALID(name, cond, msg) \
  `E2UTC_ASSERT(name, out_valid_o |-> (cond), msg)

`endif

// File: hw/rtl/e2utc_pkg.sv
// constants and month table for the epoch seconds to utc calendar block
// no dependencies
`default_nettype none

package e2utc_pkg;

  // seconds and days per unit
  localparam logic [16:0] SecsPerDay    = 17'd86400;
  localparam logic [11:0] SecsPerHour   = 12'd3600;
  localparam logic [5:0]  SecsPerMinute = 6'd60;
  localparam logic [10:0] DaysPerSpan   = 11'd1461;
  localparam logic [10:0] DaysYear1End  = 11'd365;
  localparam logic [10:0] DaysYear2End  = 11'd730;
  localparam logic [10:0] DaysYear3End  = 11'd1096;
  localparam logic [2:0]  DaysPerWeek   = 3'd7;
  localparam logic [2:0]  EpochWeekday  = 3'd4;
  localparam logic [7:0]  YearBase      = 8'd70;
  localparam logic [31:0] LastValidSecond = 32'd4102444799;

  // reciprocals for exact division by a constant (multiply then shift)
  // days    = ((secs >> 7) * DayRecip) >> 35     divides by 675
  // span    = (days * SpanRecip) >> 27           divides by 1461
  // week    = (days * WeekRecip) >> 19           divides by 7
  // hour    = ((sod >> 4) * HourRecip) >> 21     divides by 225
  // minute  = ((soh >> 2) * MinRecip) >> 14      divides by 15
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [16:0] SpanRecip = 17'd91868;
  localparam logic [16:0] WeekRecip = 17'd74899;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip  = 11'd1093;

  // last day of year of the month before idx, minus one for january
  function automatic logic signed [9:0] month_end(input logic leap, input logic [3:0] idx);
    logic signed [9:0] val;
    case (idx)
      4'd0:    val = -10'sd1;
      4'd1:    val = 10'sd30;
      4'd2:    val = leap ? 10'sd59  : 10'sd58;
      4'd3:    val = leap ? 10'sd90  : 10'sd89;
      4'd4:    val = leap ? 10'sd120 : 10'sd119;
      4'd5:    val = leap ? 10'sd151 : 10'sd150;
      4'd6:    val = leap ? 10'sd181 : 10'sd180;
      4'd7:    val = leap ? 10'sd212 : 10'sd211;
      4'd8:    val = leap ? 10'sd243 : 10'sd242;
      4'd9:    val = leap ? 10'sd273 : 10'sd272;
      4'd10:   val = leap ? 10'sd304 : 10'sd303;
      4'd11:   val = leap ? 10'sd334 : 10'sd333;
      4'd12:   val = leap ? 10'sd365 : 10'sd364;
      default: val = 10'sd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/epoch_seconds_to_utc_calendar.sv
// epoch seconds to utc calendar conversion, seven stage pipeline
// depends on e2utc_pkg and epoch_seconds_to_utc_calendar_assert.svh
`default_nettype none

// Converts a 32 bit count of seconds since 1970-01-01 00:00:00 UTC into
// year, day of year, month, day of month, weekday, hour, minute and second.
// The pipeline has seven register stages: a request passes the stage
// registers s1 to s6 and then the output registers before its result shows
// on the outputs with out_valid_o. A new request can be taken on every edge
// while no result waits under an output stall, so the sustained rate is one
// request per cycle. The depth is set by the constant-reciprocal multiplies
// (days, then four-year span, weekday and hour side by side, then minute),
// each followed by a register. A stall on the output while a result waits
// holds the whole pipeline and raises in_stall_o in the same cycle. Leap years
// are taken every fourth year, exact through 2099; range_error_o flags later inputs.

module epoch_seconds_to_utc_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] epoch_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       year_since_1900_o,
  output logic [8:0]       day_of_year_o,
  output logic [3:0]       month_index_o,
  output logic [4:0]       day_of_month_o,
  output logic [2:0]       weekday_o,
  output logic [4:0]       hour_of_day_o,
  output logic [5:0]       minute_of_hour_o,
  output logic [5:0]       second_of_minute_o,
  output logic             range_error_o
);

  `include "epoch_seconds_to_utc_calendar_assert.svh"

  // pipeline control
  logic [6:0] valid_d, valid_q;
  logic       advance;

  // stage 1: day product
  logic [50:0] s1_prod_d, s1_prod_q;
  logic [31:0] s1_secs_q;
  logic        s1_range_d, s1_range_q;

  // stage 2: days and second of day
  logic [15:0] s2_days_d, s2_days_q;
  logic [31:0] s2_sod_full;
  logic [16:0] s2_sod_d, s2_sod_q;
  logic        s2_range_q;

  // stage 3: span, week and hour products
  logic [32:0] s3_span_p_d, s3_span_p_q;
  logic [15:0] s3_dayw_d, s3_dayw_q;
  logic [32:0] s3_week_p_d, s3_week_p_q;
  logic [25:0] s3_hour_p_d, s3_hour_p_q;
  logic [15:0] s3_days_q;
  logic [16:0] s3_sod_q;
  logic        s3_range_q;

  // stage 4: span, day of span, weekday, hour, second of hour
  logic [5:0]  s4_span_d, s4_span_q;
  logic [15:0] s4_dspan_full;
  logic [10:0] s4_dspan_d, s4_dspan_q;
  logic [13:0] s4_weekq;
  logic [15:0] s4_wd_full;
  logic [2:0]  s4_wd_d, s4_wd_q;
  logic [4:0]  s4_hour_d, s4_hour_q;
  logic [16:0] s4_soh_full;
  logic [11:0] s4_soh_d, s4_soh_q;
  logic        s4_range_q;

  // stage 5: year within span, minute product
  logic [1:0]  s5_year_off;
  logic [10:0] s5_base;
  logic [10:0] s5_yday_full;
  logic [8:0]  s5_yday_d, s5_yday_q;
  logic        s5_leap_d, s5_leap_q;
  logic [7:0]  s5_year_d, s5_year_q;
  logic [19:0] s5_min_p_d, s5_min_p_q;
  logic [11:0] s5_soh_q;
  logic [4:0]  s5_hour_q;
  logic [2:0]  s5_wd_q;
  logic        s5_range_q;

  // stage 6: month and minute
  logic [10:0] s6_past;
  logic [3:0]  s6_mon_d, s6_mon_q;
  logic [5:0]  s6_minute_d, s6_minute_q;
  logic [8:0]  s6_yday_q;
  logic        s6_leap_q;
  logic [7:0]  s6_year_q;
  logic [11:0] s6_soh_q;
  logic [4:0]  s6_hour_q;
  logic [2:0]  s6_wd_q;
  logic        s6_range_q;

  // stage 7: output registers
  logic signed [9:0] s7_dom_full;
  logic [4:0]  s7_dom_d;
  logic [11:0] s7_sec_full;
  logic [5:0]  s7_sec_d;
  logic [7:0]  out_year_q;
  logic [8:0]  out_yday_q;
  logic [3:0]  out_mon_q;
  logic [4:0]  out_dom_q;
  logic [2:0]  out_wd_q;
  logic [4:0]  out_hour_q;
  logic [5:0]  out_minute_q;
  logic [5:0]  out_second_q;
  logic        out_range_q;

  // field range flags for the checks
  logic        date_ok;
  logic        clock_ok;
  logic        year_ok;

  // whole pipeline moves unless a result waits under stall
  assign advance    = !(valid_q[6] && out_stall_i);
  assign in_stall_o = !advance;
  assign valid_d    = {valid_q[5:0], in_valid_i};

  // stage 1 logic
  assign s1_prod_d  = 51'(epoch_seconds_i[31:7]) * 51'(e2utc_pkg::DayRecip);
  assign s1_range_d = epoch_seconds_i > e2utc_pkg::LastValidSecond;

  // stage 2 logic
  assign s2_days_d   = s1_prod_q[50:35];
  assign s2_sod_full = s1_secs_q - 32'(s2_days_d) * 32'(e2utc_pkg::SecsPerDay);
  assign s2_sod_d    = s2_sod_full[16:0];

  // stage 3 logic
  assign s3_span_p_d = 33'(s2_days_q) * 33'(e2utc_pkg::SpanRecip);
  assign s3_dayw_d   = s2_days_q + 16'(e2utc_pkg::EpochWeekday);
  assign s3_week_p_d = 33'(s3_dayw_d) * 33'(e2utc_pkg::WeekRecip);
  assign s3_hour_p_d = 26'(s2_sod_q[16:4]) * 26'(e2utc_pkg::HourRecip);

  // stage 4 logic
  assign s4_span_d     = s3_span_p_q[32:27];
  assign s4_dspan_full = s3_days_q - 16'(s4_span_d) * 16'(e2utc_pkg::DaysPerSpan);
  assign s4_dspan_d    = s4_dspan_full[10:0];
  assign s4_weekq      = s3_week_p_q[32:19];
  assign s4_wd_full    = s3_dayw_q - 16'(s4_weekq) * 16'(e2utc_pkg::DaysPerWeek);
  assign s4_wd_d       = s4_wd_full[2:0];
  assign s4_hour_d     = s3_hour_p_q[25:21];
  assign s4_soh_full   = s3_sod_q - 17'(s4_hour_d) * 17'(e2utc_pkg::SecsPerHour);
  assign s4_soh_d      = s4_soh_full[11:0];

  // stage 5: pick the year inside the four-year span, third one is leap
  always_comb begin
    if (s4_dspan_q < e2utc_pkg::DaysYear1End) begin
      s5_year_off = 2'd0;
      s5_base     = 11'd0;
      s5_leap_d   = 1'b0;
    end else if (s4_dspan_q < e2utc_pkg::DaysYear2End) begin
      s5_year_off = 2'd1;
      s5_base     = e2utc_pkg::DaysYear1End;
      s5_leap_d   = 1'b0;
    end else if (s4_dspan_q < e2utc_pkg::DaysYear3End) begin
      s5_year_off = 2'd2;
      s5_base     = e2utc_pkg::DaysYear2End;
      s5_leap_d   = 1'b1;
    end else begin
      s5_year_off = 2'd3;
      s5_base     = e2utc_pkg::DaysYear3End;
      s5_leap_d   = 1'b0;
    end
  end

  assign s5_yday_full = s4_dspan_q - s5_base;
  assign s5_yday_d    = s5_yday_full[8:0];
  assign s5_year_d    = 8'({s4_span_q, 2'b00}) + e2utc_pkg::YearBase + 8'(s5_year_off);
  assign s5_min_p_d   = 20'(s4_soh_q[11:2]) * 20'(e2utc_pkg::MinRecip);

  // stage 6: month is the number of month ends that lie before the day
  always_comb begin
    for (int m = 1; m < 12; m++) begin
      s6_past[m-1] = e2utc_pkg::month_end(s5_leap_q, 4'(m)) < $signed({1'b0, s5_yday_q});
    end
  end

  assign s6_mon_d    = 4'($countones(s6_past));
  assign s6_minute_d = s5_min_p_q[19:14];

  // stage 7: day of month and second
  assign s7_dom_full = $signed({1'b0, s6_yday_q}) - e2utc_pkg::month_end(s6_leap_q, s6_mon_q);
  assign s7_dom_d    = s7_dom_full[4:0];
  assign s7_sec_full = s6_soh_q - 12'(s6_minute_q) * 12'(e2utc_pkg::SecsPerMinute);
  assign s7_sec_d    = s7_sec_full[5:0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q    <= s1_prod_d;
      s1_secs_q    <= epoch_seconds_i;
      s1_range_q   <= s1_range_d;

      s2_days_q    <= s2_days_d;
      s2_sod_q     <= s2_sod_d;
      s2_range_q   <= s1_range_q;

      s3_span_p_q  <= s3_span_p_d;
      s3_dayw_q    <= s3_dayw_d;
      s3_week_p_q  <= s3_week_p_d;
      s3_hour_p_q  <= s3_hour_p_d;
      s3_days_q    <= s2_days_q;
      s3_sod_q     <= s2_sod_q;
      s3_range_q   <= s2_range_q;

      s4_span_q    <= s4_span_d;
      s4_dspan_q   <= s4_dspan_d;
      s4_wd_q      <= s4_wd_d;
      s4_hour_q    <= s4_hour_d;
      s4_soh_q     <= s4_soh_d;
      s4_range_q   <= s3_range_q;

      s5_yday_q    <= s5_yday_d;
      s5_leap_q    <= s5_leap_d;
      s5_year_q    <= s5_year_d;
      s5_min_p_q   <= s5_min_p_d;
      s5_soh_q     <= s4_soh_q;
      s5_hour_q    <= s4_hour_q;
      s5_wd_q      <= s4_wd_q;
      s5_range_q   <= s4_range_q;

      s6_mon_q     <= s6_mon_d;
      s6_minute_q  <= s6_minute_d;
      s6_yday_q    <= s5_yday_q;
      s6_leap_q    <= s5_leap_q;
      s6_year_q    <= s5_year_q;
      s6_soh_q     <= s5_soh_q;
      s6_hour_q    <= s5_hour_q;
      s6_wd_q      <= s5_wd_q;
      s6_range_q   <= s5_range_q;

      out_year_q   <= s6_year_q;
      out_yday_q   <= s6_yday_q;
      out_mon_q    <= s6_mon_q;
      out_dom_q    <= s7_dom_d;
      out_wd_q     <= s6_wd_q;
      out_hour_q   <= s6_hour_q;
      out_minute_q <= s6_minute_q;
      out_second_q <= s7_sec_d;
      out_range_q  <= s6_range_q;
    end
  end

  // result ports
  assign out_valid_o        = valid_q[6];
  assign year_since_1900_o  = out_year_q;
  assign day_of_year_o      = out_yday_q;
  assign month_index_o      = out_mon_q;
  assign day_of_month_o     = out_dom_q;
  assign weekday_o          = out_wd_q;
  assign hour_of_day_o      = out_hour_q;
  assign minute_of_hour_o   = out_minute_q;
  assign second_of_minute_o = out_second_q;
  assign range_error_o      = out_range_q;

  // range flags on the result fields
  assign date_ok  = (month_index_o <= 4'd11) && (day_of_month_o != 5'd0) &&
                    (day_of_year_o <= 9'd365);
  assign clock_ok = (hour_of_day_o <= 5'd23) && (minute_of_hour_o <= 6'd59) &&
                    (second_of_minute_o <= 6'd59) && (weekday_o <= 3'd6);
  assign year_ok  = range_error_o ||
                    (year_since_1900_o >= 8'd70 && year_since_1900_o <= 8'd199);

  // checks on the conversion results and the stall path
  `E2UTC_ASSERT_VALID(a_date_range, date_ok, "date field out of range")
  `E2UTC_ASSERT_VALID(a_clock_range, clock_ok, "clock field out of range")
  `E2UTC_ASSERT_VALID(a_year_range, year_ok, "year out of range without range flag")
  `E2UTC_ASSERT(a_stall_back, out_valid_o && out_stall_i |-> in_stall_o, "input taken while held")

endmodule

`default_nettype wire

// File: bench/epoch_seconds_to_utc_calendar_test.sv
// self-checking bench for epoch_seconds_to_utc_calendar: directed and random requests
// a built-in calendar predictor in a small scoreboard class checks every result
// depends only on the epoch_seconds_to_utc_calendar rtl
module epoch_seconds_to_utc_calendar_test;

  // calendar arithmetic
  localparam int unsigned DaySecs    = 86400;
  localparam int unsigned HourSecs   = 3600;
  localparam int unsigned MinSecs    = 60;
  localparam int unsigned YearSecs   = 365 * DaySecs;
  localparam int unsigned LeapSecs   = 366 * DaySecs;
  localparam int unsigned SpanSecs   = 1461 * DaySecs;
  localparam int unsigned FirstDay   = 4;
  localparam int unsigned BaseYear   = 70;
  localparam logic [31:0] LastSecond = 32'd4102444799;
  localparam int NormalEnds [13] = '{-1, 30, 58, 89, 119, 150, 180, 211, 242, 272, 303, 333, 364};
  localparam int LeapEnds   [13] = '{-1, 30, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  // run shape
  localparam int RandomItems = 700;
  localparam int PipeDepth   = 7;
  localparam int CycleLimit  = 200000;

  typedef struct packed {
    logic [7:0] year;
    logic [8:0] yday;
    logic [3:0] month;
    logic [4:0] mday;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] sec;
    logic       range_err;
  } calendar_t;

  // expected calendar dates, oldest first
  class calendar_board;
    calendar_t pending_dates[$];
    int        errors = 0;

    // broken-down utc date of a seconds count, four-year leap rule
    static function calendar_t calendar_of(logic [31:0] secs);
      int unsigned span, rest, yday, sod, hr, mn, mon;
      int          month_end;
      logic [7:0]  yr;
      logic        leap;
      calendar_t   c;
      span = secs / SpanSecs;
      rest = secs - span * SpanSecs;
      yr   = 8'(span * 4 + BaseYear);
      leap = 1'b0;
      if (rest >= YearSecs) begin
        yr++;
        rest -= YearSecs;
        if (rest >= YearSecs) begin
          yr++;
          rest -= YearSecs;
          if (rest >= LeapSecs) begin
            yr++;
            rest -= LeapSecs;
          end else begin
            leap = 1'b1;
          end
        end
      end
      yday = rest / DaySecs;
      sod  = rest - yday * DaySecs;
      // first month whose end is not before the day of year
      mon = 1;
      month_end = leap ? LeapEnds[1] : NormalEnds[1];
      while (mon < 12 && month_end < int'(yday)) begin
        mon++;
        month_end = leap ? LeapEnds[mon] : NormalEnds[mon];
      end
      mon--;
      month_end = leap ? LeapEnds[mon] : NormalEnds[mon];
      hr = sod / HourSecs;
      mn = (sod - hr * HourSecs) / MinSecs;
      c.year      = yr;
      c.yday      = 9'(yday);
      c.month     = 4'(mon);
      c.mday      = 5'(int'(yday) - month_end);
      c.wday      = 3'((secs / DaySecs + FirstDay) % 7);
      c.hour      = 5'(hr);
      c.minute    = 6'(mn);
      c.sec       = 6'(sod - hr * HourSecs - mn * MinSecs);
      c.range_err = secs > LastSecond;
      return c;
    endfunction

    function void note_request(logic [31:0] secs);
      pending_dates.push_back(calendar_of(secs));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_date(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("year_since_1900", want.year, got.year);
      compare_field("day_of_year", want.yday, got.yday);
      compare_field("month_index", want.month, got.month);
      compare_field("day_of_month", want.mday, got.mday);
      compare_field("weekday", want.wday, got.wday);
      compare_field("hour_of_day", want.hour, got.hour);
      compare_field("minute_of_hour", want.minute, got.minute);
      compare_field("second_of_minute", want.sec, got.sec);
      compare_field("range_error", want.range_err, got.range_err);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] epoch_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  year_since_1900_o;
  logic [8:0]  day_of_year_o;
  logic [3:0]  month_index_o;
  logic [4:0]  day_of_month_o;
  logic [2:0]  weekday_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;
  logic [5:0]  second_of_minute_o;
  logic        range_error_o;

  calendar_board board = new();
  int            sent_count = 0;
  bit            idle_on = 1'b1;
  int            stall_left = 0;
  int            cycle_count = 0;

  epoch_seconds_to_utc_calendar i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .epoch_seconds_i,
    .out_valid_o,
    .out_stall_i,
    .year_since_1900_o,
    .day_of_year_o,
    .month_index_o,
    .day_of_month_o,
    .weekday_o,
    .hour_of_day_o,
    .minute_of_hour_o,
    .second_of_minute_o,
    .range_error_o
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("epoch_seconds_to_utc_calendar_test: done, errors");
        $finish;
      end
    end
  end

  // seconds count of a date, leap year every fourth year from 1972
  function automatic logic [31:0] epoch_of(int yr, int yday, int sod);
    longint days;
    days = longint'(yr - 70) * 365 + (yr - 69) / 4 + yday;
    return 32'(days * DaySecs + sod);
  endfunction

  // offer one request, with an occasional gap before it, and wait for it to be taken
  task automatic send_request(input logic [31:0] secs);
    int gap;
    idle_on = (sent_count < 250) || (sent_count >= 350 && sent_count < RandomItems - 100);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(secs);
    sent_count++;
  endtask

  // random request: anywhere, near a month or day edge, or around the end of 2099
  task automatic send_random_request();
    int sod;
    case ($urandom_range(0, 4))
      0, 1: send_request($urandom());
      2, 3: begin
        case ($urandom_range(0, 3))
          0: sod = 0;
          1: sod = DaySecs - 1;
          2: sod = HourSecs * $urandom_range(0, 23) + $urandom_range(0, 1) * (HourSecs - 1);
          default: sod = $urandom_range(0, DaySecs - 1);
        endcase
        send_request(epoch_of($urandom_range(70, 206),
                              NormalEnds[$urandom_range(0, 12)] + $urandom_range(0, 2), sod));
      end
      default: send_request(LastSecond + $urandom_range(0, 8) - 4);
    endcase
  endtask

  // result side: check taken results and stall in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_date({year_since_1900_o, day_of_year_o, month_index_o, day_of_month_o,
                          weekday_o, hour_of_day_o, minute_of_hour_o, second_of_minute_o,
                          range_error_o});
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // epoch and time of day edges
    send_request(32'd0);
    send_request(32'd59);
    send_request(32'd60);
    send_request(32'd3599);
    send_request(32'd3600);
    send_request(32'd86399);
    send_request(32'd86400);
    // year edges in normal and leap years
    send_request(epoch_of(70, 364, DaySecs - 1));
    send_request(epoch_of(71, 0, 0));
    send_request(epoch_of(72, 59, 0));
    send_request(epoch_of(72, 365, DaySecs - 1));
    send_request(epoch_of(73, 0, 0));
    send_request(epoch_of(73, 58, DaySecs - 1));
    send_request(epoch_of(73, 59, 0));
    send_request(epoch_of(100, 59, 43200));
    // end of the valid range and beyond, where 2100 counts as leap
    send_request(LastSecond);
    send_request(LastSecond + 1);
    send_request(epoch_of(200, 59, 0));
    send_request(32'hFFFF_FFFF);
    // bit patterns
    send_request(32'h8000_0000);
    send_request(32'h7FFF_FFFF);
    send_request(32'h5555_5555);
    send_request(32'hAAAA_AAAA);

    repeat (RandomItems) send_random_request();
    in_valid_i <= 1'b0;

    // drain, then watch for stray results
    while (board.pending_dates.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("epoch_seconds_to_utc_calendar_test: done, clean");
    end else begin
      $display("epoch_seconds_to_utc_calendar_test: done, errors");
    end
    $finish;
  end

endmodule
